FILE: sv/ohlc_pkg.sv
`timescale 1ns / 1ps

package ohlc_pkg;

    localparam int FIELD_WIDTH     = 32;
    localparam int PRICE_WIDTH_DEF = 32;
    localparam int SUM_WIDTH_DEF   = 64;

endpackage

FILE: sv/ohlc_if.sv
`timescale 1ns / 1ps

interface trade_if
    import ohlc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] price;
    logic [FIELD_WIDTH-1:0] amount;
    logic [FIELD_WIDTH-1:0] bucket_id;

    modport source (output valid, output price, output amount, output bucket_id, input ready);
    modport sink   (input valid, input price, input amount, input bucket_id, output ready);
endinterface

interface bar_if
    import ohlc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   new_bar;
    logic [FIELD_WIDTH-1:0] bar_high;
    logic [FIELD_WIDTH-1:0] bar_low;
    logic [FIELD_WIDTH-1:0] bar_open;
    logic [FIELD_WIDTH-1:0] bar_close;
    logic [FIELD_WIDTH-1:0] bar_bucket;
    logic [FIELD_WIDTH-1:0] run_high;
    logic [FIELD_WIDTH-1:0] run_low;
    logic                   sum_saturated;

    modport source (
        output valid, output new_bar, output bar_high, output bar_low, output bar_open,
        output bar_close, output bar_bucket, output run_high, output run_low,
        output sum_saturated, input ready
    );
    modport sink (
        input valid, input new_bar, input bar_high, input bar_low, input bar_open,
        input bar_close, input bar_bucket, input run_high, input run_low,
        input sum_saturated, output ready
    );
endinterface

FILE: sv/ohlc_div.sv
`timescale 1ns / 1ps

module ohlc_div
    import ohlc_pkg::*;
#(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
    parameter int SUM_WIDTH   = SUM_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SUM_WIDTH-1:0]   dividend,
    input  logic [SUM_WIDTH-1:0]   divisor,
    output logic                   done,
    output logic [PRICE_WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(PRICE_WIDTH + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN,
        D_DONE
    } div_state_t;

    div_state_t             state_reg;
    logic [SUM_WIDTH-1:0]   rem_reg;
    logic [SUM_WIDTH-1:0]   dvs_reg;
    logic [PRICE_WIDTH-1:0] low_reg;
    logic [PRICE_WIDTH-1:0] quo_reg;
    logic [CNT_W-1:0]       cnt_reg;

    logic [SUM_WIDTH:0]     shifted;
    logic [SUM_WIDTH:0]     diff;
    logic                   ge;

    assign shifted = {rem_reg, low_reg[PRICE_WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = !diff[SUM_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            dvs_reg   <= '0;
            low_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= SUM_WIDTH'(dividend[SUM_WIDTH-1:PRICE_WIDTH]);
                        low_reg   <= dividend[PRICE_WIDTH-1:0];
                        dvs_reg   <= divisor;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    // quotient does not fit: clamp to the largest price
                    if (rem_reg >= dvs_reg)
                    begin
                        quo_reg   <= '1;
                        state_reg <= D_DONE;
                    end
                    else
                    begin
                        quo_reg   <= '0;
                        cnt_reg   <= CNT_W'(PRICE_WIDTH);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? diff[SUM_WIDTH-1:0] : shifted[SUM_WIDTH-1:0];
                    low_reg <= {low_reg[PRICE_WIDTH-2:0], 1'b0};
                    quo_reg <= {quo_reg[PRICE_WIDTH-2:0], ge};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done     = (state_reg == D_DONE);
    assign quotient = quo_reg;

endmodule

FILE: sv/ohlc_vwap_bar_aggregator.sv
`timescale 1ns / 1ps

// OHLC bar aggregator with volume-weighted close. Each trade beat updates the
// current bar (opened anew when the bucket id changes, or on the first trade)
// and yields one bar beat with high, low, open, VWAP close, bucket, running
// high/low and a sum saturation flag. No new trade is accepted until that bar
// beat has been registered: each trade passes through the multiply, two
// saturating sums on a shared adder, and a restoring divider that runs an
// overflow check and then yields one quotient bit per cycle. A quotient too
// wide for a price clamps right after the check. A trade whose amount sum is
// zero skips the divider and keeps the previous close. A finished bar beat
// waits in its output register while the next trade is taken.
module ohlc_vwap_bar_aggregator
    import ohlc_pkg::*;
#(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
    parameter int SUM_WIDTH   = SUM_WIDTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    trade_if.sink  trade,
    bar_if.source  bar
);

    localparam int PROD_W = 2 * PRICE_WIDTH;
    localparam int ACC_W  = ((PROD_W > SUM_WIDTH) ? PROD_W : SUM_WIDTH) + 1;

    localparam logic [ACC_W-1:0] SMASK_W = ACC_W'({SUM_WIDTH{1'b1}});

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_VADD,
        S_AADD,
        S_DIVGO,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                 state_reg;

    logic [PRICE_WIDTH-1:0] price_reg;
    logic [PRICE_WIDTH-1:0] amount_reg;
    logic [FIELD_WIDTH-1:0] bucket_in_reg;
    logic [PROD_W-1:0]      product_reg;
    logic                   opened_reg;

    logic                   have_bar_reg;
    logic [PRICE_WIDTH-1:0] high_reg;
    logic [PRICE_WIDTH-1:0] low_reg;
    logic [PRICE_WIDTH-1:0] open_reg;
    logic [PRICE_WIDTH-1:0] close_reg;
    logic [FIELD_WIDTH-1:0] bucket_reg;
    logic [SUM_WIDTH-1:0]   value_sum_reg;
    logic [SUM_WIDTH-1:0]   amount_sum_reg;
    logic [PRICE_WIDTH-1:0] all_high_reg;
    logic [FIELD_WIDTH-1:0] all_low_reg;
    logic                   sat_reg;

    logic                   out_valid_reg;
    logic                   out_new_bar_reg;
    logic [FIELD_WIDTH-1:0] out_high_reg;
    logic [FIELD_WIDTH-1:0] out_low_reg;
    logic [FIELD_WIDTH-1:0] out_open_reg;
    logic [FIELD_WIDTH-1:0] out_close_reg;
    logic [FIELD_WIDTH-1:0] out_bucket_reg;
    logic [FIELD_WIDTH-1:0] out_run_high_reg;
    logic [FIELD_WIDTH-1:0] out_run_low_reg;
    logic                   out_sat_reg;

    logic [ACC_W-1:0]       add_a;
    logic [ACC_W-1:0]       add_b;
    logic [ACC_W-1:0]       add_sum;
    logic                   add_sat;
    logic [SUM_WIDTH-1:0]   add_res;
    logic                   is_new;
    logic                   emit_fire;
    logic                   div_start;
    logic                   div_done;
    logic [PRICE_WIDTH-1:0] div_quo;

    // shared saturating adder: value sum, then amount sum
    always_comb
    begin
        if (state_reg == S_AADD)
        begin
            add_a = opened_reg ? '0 : ACC_W'(amount_sum_reg);
            add_b = ACC_W'(amount_reg);
        end
        else
        begin
            add_a = opened_reg ? '0 : ACC_W'(value_sum_reg);
            add_b = ACC_W'(product_reg);
        end
    end

    assign add_sum   = add_a + add_b;
    assign add_sat   = (add_sum > SMASK_W);
    assign add_res   = add_sat ? {SUM_WIDTH{1'b1}} : add_sum[SUM_WIDTH-1:0];
    assign is_new    = !have_bar_reg || (bucket_in_reg != bucket_reg);
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || bar.ready);
    assign div_start = (state_reg == S_DIVGO) && (amount_sum_reg != '0);

    ohlc_div #(
        .PRICE_WIDTH (PRICE_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (value_sum_reg),
        .divisor  (amount_sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            price_reg        <= '0;
            amount_reg       <= '0;
            bucket_in_reg    <= '0;
            product_reg      <= '0;
            opened_reg       <= 1'b0;
            have_bar_reg     <= 1'b0;
            high_reg         <= '0;
            low_reg          <= '0;
            open_reg         <= '0;
            close_reg        <= '0;
            bucket_reg       <= '0;
            value_sum_reg    <= '0;
            amount_sum_reg   <= '0;
            all_high_reg     <= '0;
            all_low_reg      <= '1;
            sat_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_new_bar_reg  <= 1'b0;
            out_high_reg     <= '0;
            out_low_reg      <= '0;
            out_open_reg     <= '0;
            out_close_reg    <= '0;
            out_bucket_reg   <= '0;
            out_run_high_reg <= '0;
            out_run_low_reg  <= '0;
            out_sat_reg      <= 1'b0;
        end
        else
        begin
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (bar.valid && bar.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (trade.valid)
                    begin
                        price_reg     <= trade.price[PRICE_WIDTH-1:0];
                        amount_reg    <= trade.amount[PRICE_WIDTH-1:0];
                        bucket_in_reg <= trade.bucket_id;
                        state_reg     <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    product_reg <= PROD_W'(price_reg) * PROD_W'(amount_reg);
                    opened_reg  <= is_new;
                    if (price_reg > all_high_reg)
                    begin
                        all_high_reg <= price_reg;
                    end
                    if (FIELD_WIDTH'(price_reg) < all_low_reg)
                    begin
                        all_low_reg <= FIELD_WIDTH'(price_reg);
                    end
                    if (is_new)
                    begin
                        // open at the previous close; the close carries over
                        open_reg     <= close_reg;
                        high_reg     <= price_reg;
                        low_reg      <= price_reg;
                        bucket_reg   <= bucket_in_reg;
                        have_bar_reg <= 1'b1;
                        sat_reg      <= 1'b0;
                    end
                    else
                    begin
                        if (price_reg > high_reg)
                        begin
                            high_reg <= price_reg;
                        end
                        if (price_reg < low_reg)
                        begin
                            low_reg <= price_reg;
                        end
                    end
                    state_reg <= S_VADD;
                end
                S_VADD:
                begin
                    value_sum_reg <= add_res;
                    sat_reg       <= sat_reg | add_sat;
                    state_reg     <= S_AADD;
                end
                S_AADD:
                begin
                    amount_sum_reg <= add_res;
                    sat_reg        <= sat_reg | add_sat;
                    state_reg      <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    state_reg <= (amount_sum_reg != '0) ? S_DIV : S_EMIT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        close_reg <= div_quo;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_new_bar_reg  <= opened_reg;
                        out_high_reg     <= FIELD_WIDTH'(high_reg);
                        out_low_reg      <= FIELD_WIDTH'(low_reg);
                        out_open_reg     <= FIELD_WIDTH'(open_reg);
                        out_close_reg    <= FIELD_WIDTH'(close_reg);
                        out_bucket_reg   <= bucket_reg;
                        out_run_high_reg <= FIELD_WIDTH'(all_high_reg);
                        out_run_low_reg  <= all_low_reg;
                        out_sat_reg      <= sat_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign trade.ready       = (state_reg == S_IDLE);
    assign bar.valid         = out_valid_reg;
    assign bar.new_bar       = out_new_bar_reg;
    assign bar.bar_high      = out_high_reg;
    assign bar.bar_low       = out_low_reg;
    assign bar.bar_open      = out_open_reg;
    assign bar.bar_close     = out_close_reg;
    assign bar.bar_bucket    = out_bucket_reg;
    assign bar.run_high      = out_run_high_reg;
    assign bar.run_low       = out_run_low_reg;
    assign bar.sum_saturated = out_sat_reg;

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && !bar.ready) |=> state_reg == S_EMIT)
        else $error("emit left while output beat still pending");

    a_bar_order: assert property (@(posedge clk) disable iff (!rst_n)
        have_bar_reg |-> low_reg <= high_reg)
        else $error("bar low above bar high");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        have_bar_reg |-> all_low_reg <= FIELD_WIDTH'(all_high_reg))
        else $error("running low above running high");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_out_after_bar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> have_bar_reg)
        else $error("bar beat without an open bar");

endmodule
